// ===== rtl/lzd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared types and constants of the byte stream LZ77 decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzd_pkg;

  // default history size in bytes
  localparam int HIST_DEPTH_DEF = 2048;

  // compressed format constants
  localparam int          DIST_W     = 11;
  localparam logic [7:0]  SPACE_CHAR = 8'h20;
  localparam logic [7:0]  XOR_MASK   = 8'h80;
  localparam logic [7:0]  PAIR_MIN   = 8'h80;
  localparam logic [7:0]  SPACE_MIN  = 8'hC0;
  localparam logic [7:0]  PASS_MIN   = 8'h09;
  localparam logic [3:0]  LEN_BIAS   = 4'd3;

  // kind of output job queued for the issue stage
  typedef enum logic [1:0] {
    JOB_LIT,
    JOB_SPACE,
    JOB_COPY
  } job_kind_t;

  // where the emit stage takes its byte from
  typedef enum logic [1:0] {
    SRC_LIT,
    SRC_MEM,
    SRC_FWD
  } byte_src_t;

  // one result request, as queued toward the output
  typedef struct packed {
    logic       bad;
    logic       last;
    logic [7:0] data;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/lzd_hist_mem.sv =====
// ----------------------------------------------------------------------------
// lzd_hist_mem
// History RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lzd_hist_mem
  import lzd_pkg::*;
#(
  parameter int DEPTH = HIST_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lzd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// lzd_out_fifo
// Two-entry output queue between the emit stage and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lzd_out_fifo
  import lzd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire out_item_t push_item,
  input  wire logic      pop,
  output logic           valid,
  output out_item_t      head,
  output logic [1:0]     count
);

  out_item_t  slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_pop;

  assign do_pop = pop && (count_r != 2'd0);
  assign valid  = (count_r != 2'd0);
  assign head   = slot_r[rd_ptr_r];
  assign count  = count_r;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, do_pop};
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lz77_byte_stream_decompressor.sv =====
// ----------------------------------------------------------------------------
// lz77_byte_stream_decompressor
// Decodes one compressed byte per request into zero to ten output bytes,
// keeping the produced bytes in a circular history RAM for back-references.
// ----------------------------------------------------------------------------
//  channel | ports                        | contents
//  --------+------------------------------+----------------------------------
//  in      | in_tvalid/in_tready          | tdata: in_byte, tlast: in_last
//  out     | out_tvalid/out_tready        | tdata: out_byte, tlast: out_last,
//          |                              | tuser: bad_distance
//
//  An input byte is decoded in its accept cycle into a job count; jobs then
//  issue one per cycle while the output queue has room (history read for
//  copies) and are written back in the following cycle. Reset is
//  synchronous and clears all control state; the history needs no clearing.
//  A stalled output fills a two-entry queue and then holds the issue stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lz77_byte_stream_decompressor
  import lzd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HIST_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic      [7:0] out_tdata,  // [7:0] out_byte
  output logic            out_tlast,
  output logic            out_tuser   // [0] bad_distance
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);

  // decode state
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [3:0]        run_r, run_nxt;
  logic              pair_r, pair_nxt;
  logic [7:0]        high_r, high_nxt;

  // issue stage
  logic [3:0]        gen_cnt_r, gen_cnt_nxt;
  job_kind_t         gen_kind_r, gen_kind_nxt;
  logic [7:0]        gen_lit_r, gen_lit_nxt;
  logic [DIST_W-1:0] gen_dist_r, gen_dist_nxt;
  logic [AW-1:0]     gen_addr_r, gen_addr_nxt;
  logic [CW-1:0]     gen_avail_r, gen_avail_nxt;
  logic              gen_end_r, gen_end_nxt;

  // emit stage
  logic              s2_valid_r, s2_valid_nxt;
  byte_src_t         s2_src_r, s2_src_nxt;
  logic [7:0]        s2_lit_r, s2_lit_nxt;
  logic              s2_bad_r, s2_bad_nxt;
  logic              s2_last_r, s2_last_nxt;
  logic              s2_end_r, s2_end_nxt;
  logic [7:0]        last_byte_r, last_byte_nxt;

  logic              in_fire;
  logic              out_pop;
  logic              room;
  logic              issue;
  logic              copy_bad;
  logic [DIST_W-1:0] dec_dist;
  logic [CW-1:0]     dec_base;
  logic [7:0]        emit_byte;
  logic [7:0]        mem_rdata;
  logic [1:0]        fifo_cnt;
  out_item_t         push_item;
  out_item_t         head;

  assign in_tready = (gen_cnt_r == 4'd0) && !s2_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_pop   = out_tvalid && out_tready;

  // issue only when the queue can hold this job once it is written back
  assign room  = ({1'b0, fifo_cnt} + {2'b00, s2_valid_r}) < (3'd2 + {2'b00, out_pop});
  assign issue = (gen_cnt_r != 4'd0) && room;

  assign copy_bad = (gen_dist_r == '0) ||
                    ({{(CW-DIST_W){1'b0}}, gen_dist_r} > gen_avail_r);

  // pair distance and copy start address
  assign dec_dist = {high_r[5:0], in_tdata[7:3]};
  assign dec_base = {1'b0, wp_r} + DEPTH_C - {{(CW-DIST_W){1'b0}}, dec_dist};

  // emit byte selection
  always_comb begin
    unique case (s2_src_r)
      SRC_MEM: emit_byte = mem_rdata;
      SRC_FWD: emit_byte = last_byte_r;
      default: emit_byte = s2_lit_r;
    endcase
  end

  // next state of decode, issue and emit stages
  always_comb begin
    wp_nxt        = wp_r;
    cnt_nxt       = cnt_r;
    run_nxt       = run_r;
    pair_nxt      = pair_r;
    high_nxt      = high_r;
    gen_cnt_nxt   = gen_cnt_r;
    gen_kind_nxt  = gen_kind_r;
    gen_lit_nxt   = gen_lit_r;
    gen_dist_nxt  = gen_dist_r;
    gen_addr_nxt  = gen_addr_r;
    gen_avail_nxt = gen_avail_r;
    gen_end_nxt   = gen_end_r;
    s2_valid_nxt  = issue;
    s2_src_nxt    = s2_src_r;
    s2_lit_nxt    = s2_lit_r;
    s2_bad_nxt    = s2_bad_r;
    s2_last_nxt   = s2_last_r;
    s2_end_nxt    = s2_end_r;
    last_byte_nxt = last_byte_r;

    // issue one job
    if (issue) begin
      gen_cnt_nxt = gen_cnt_r - 4'd1;
      s2_last_nxt = (gen_cnt_r == 4'd1);
      s2_end_nxt  = gen_end_r && (gen_cnt_r == 4'd1);
      s2_bad_nxt  = 1'b0;
      s2_src_nxt  = SRC_LIT;
      s2_lit_nxt  = gen_lit_r;
      unique case (gen_kind_r)
        JOB_SPACE: begin
          s2_lit_nxt   = SPACE_CHAR;
          gen_kind_nxt = JOB_LIT;
        end
        JOB_COPY: begin
          if (copy_bad) begin
            s2_bad_nxt = 1'b1;
            s2_lit_nxt = 8'h00;
          end else if (gen_dist_r == DIST_W'(1)) begin
            s2_src_nxt = SRC_FWD;
          end else begin
            s2_src_nxt = SRC_MEM;
          end
          gen_addr_nxt = (gen_addr_r == LAST_IDX) ? '0 : gen_addr_r + AW'(1);
          if (gen_avail_r != DEPTH_C) begin
            gen_avail_nxt = gen_avail_r + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end

    // write-back of the emitted byte
    if (s2_valid_r) begin
      last_byte_nxt = emit_byte;
      if (s2_end_r) begin
        wp_nxt  = '0;
        cnt_nxt = '0;
      end else begin
        wp_nxt = (wp_r == LAST_IDX) ? '0 : wp_r + AW'(1);
        if (cnt_r != DEPTH_C) begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
    end

    // decode an accepted byte
    if (in_fire) begin
      gen_end_nxt = in_tlast;
      gen_lit_nxt = in_tdata;
      gen_kind_nxt = JOB_LIT;
      if (run_r != 4'd0) begin
        run_nxt     = run_r - 4'd1;
        gen_cnt_nxt = 4'd1;
      end else if (pair_r) begin
        pair_nxt      = 1'b0;
        high_nxt      = 8'h00;
        gen_kind_nxt  = JOB_COPY;
        gen_cnt_nxt   = {1'b0, in_tdata[2:0]} + LEN_BIAS;
        gen_dist_nxt  = dec_dist;
        gen_avail_nxt = cnt_r;
        gen_addr_nxt  = (dec_base >= DEPTH_C) ? AW'(dec_base - DEPTH_C) : AW'(dec_base);
      end else if (in_tdata >= SPACE_MIN) begin
        gen_kind_nxt = JOB_SPACE;
        gen_lit_nxt  = in_tdata ^ XOR_MASK;
        gen_cnt_nxt  = 4'd2;
      end else if (in_tdata >= PAIR_MIN) begin
        pair_nxt = 1'b1;
        high_nxt = in_tdata;
      end else if ((in_tdata >= PASS_MIN) || (in_tdata == 8'h00)) begin
        gen_cnt_nxt = 4'd1;
      end else begin
        run_nxt = in_tdata[3:0];
      end
      // record end drops any open run or pair
      if (in_tlast) begin
        run_nxt  = 4'd0;
        pair_nxt = 1'b0;
        high_nxt = 8'h00;
        if (gen_cnt_nxt == 4'd0) begin
          wp_nxt  = '0;
          cnt_nxt = '0;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      cnt_r      <= '0;
      run_r      <= 4'd0;
      pair_r     <= 1'b0;
      high_r     <= 8'h00;
      gen_cnt_r  <= 4'd0;
      s2_valid_r <= 1'b0;
    end else begin
      wp_r       <= wp_nxt;
      cnt_r      <= cnt_nxt;
      run_r      <= run_nxt;
      pair_r     <= pair_nxt;
      high_r     <= high_nxt;
      gen_cnt_r  <= gen_cnt_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    gen_kind_r  <= gen_kind_nxt;
    gen_lit_r   <= gen_lit_nxt;
    gen_dist_r  <= gen_dist_nxt;
    gen_addr_r  <= gen_addr_nxt;
    gen_avail_r <= gen_avail_nxt;
    gen_end_r   <= gen_end_nxt;
    s2_src_r    <= s2_src_nxt;
    s2_lit_r    <= s2_lit_nxt;
    s2_bad_r    <= s2_bad_nxt;
    s2_last_r   <= s2_last_nxt;
    s2_end_r    <= s2_end_nxt;
    last_byte_r <= last_byte_nxt;
  end

  // history RAM
  lzd_hist_mem #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk   (clk),
    .we    (s2_valid_r),
    .waddr (wp_r),
    .wdata (emit_byte),
    .re    (issue && (gen_kind_r == JOB_COPY)),
    .raddr (gen_addr_r),
    .rdata (mem_rdata)
  );

  // output queue
  assign push_item.bad  = s2_bad_r;
  assign push_item.last = s2_last_r;
  assign push_item.data = emit_byte;

  lzd_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_valid_r),
    .push_item (push_item),
    .pop       (out_tready),
    .valid     (out_tvalid),
    .head      (head),
    .count     (fifo_cnt)
  );

  assign out_tdata = head.data;
  assign out_tlast = head.last;
  assign out_tuser = head.bad;

endmodule

`default_nettype wire

// ===== rtl/lzd_checker.sv =====
// ----------------------------------------------------------------------------
// lzd_checker
// Port-level checks of the decompressor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lzd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic [7:0] in_tdata,
  input wire logic       in_tlast,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast,
  input wire logic       out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // a bad distance always carries a zero byte
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 8'h00)
    else $error("bad distance with nonzero byte");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

  // a record end accepted while the result stalls saw the result offered
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast && out_tvalid && !out_tready
      |=> $past(out_tvalid))
    else $error("input accept check failed");

endmodule

bind lz77_byte_stream_decompressor lzd_checker u_chk (.*);

`default_nettype wire

// ===== sim/lz77_byte_stream_decompressor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_byte_stream_decompressor_tb
// Streams compressed records into the decompressor and checks every output
// byte against a behavioral decoder that keeps its own history and run state.
// Directed bytes cover each byte class, overlap, bad distances and record
// ends. Random records follow, one of them pass bytes then longest copies.
// ----------------------------------------------------------------------------
module lz77_byte_stream_decompressor_tb;
  import lzd_pkg::*;

  localparam int HDEPTH = HIST_DEPTH_DEF;

  // one compressed byte waiting to be sent
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       hold;  // wait until all output has drained before sending
  } comp_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tready = 1'b0;
  wire        in_tready;
  wire        out_tvalid;
  wire  [7:0] out_tdata;
  wire        out_tlast;
  wire        out_tuser;

  comp_t      comp_q[$];
  out_item_t  byte_q[$];
  out_item_t  want;
  int         n_total = 0;
  int         n_acc   = 0;
  int         n_err   = 0;

  // decoder state
  logic [7:0]        hist [0:HDEPTH-1];
  logic [DIST_W-1:0] wr_ptr   = '0;
  int                produced = 0;
  logic [3:0]        run_left = '0;
  logic              pair_pend = 1'b0;
  logic [7:0]        pair_hi  = '0;

  // idle phases: sender light / receiver heavy, then swapped, then none
  wire [1:0] idle_phase = (n_acc * 3 < n_total) ? 2'd0 :
                          (n_acc * 3 < 2 * n_total) ? 2'd1 : 2'd2;
  wire [6:0] send_idle  = (idle_phase == 2'd0) ? 7'd22 : (idle_phase == 2'd1) ? 7'd80 : 7'd0;
  wire [6:0] recv_idle  = (idle_phase == 2'd0) ? 7'd80 : (idle_phase == 2'd1) ? 7'd22 : 7'd0;

  lz77_byte_stream_decompressor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [7:0] in_byte
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),   // [7:0] out_byte
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)    // [0] bad_distance
  );

  always #1 clk = ~clk;

  // append one produced byte to the expected stream and the history
  task automatic emit_byte(input logic [7:0] b, input logic bad);
    out_item_t r;
    r.data = b;
    r.last = 1'b0;
    r.bad  = bad;
    byte_q.push_back(r);
    hist[wr_ptr] = b;
    wr_ptr = wr_ptr + 1'b1;
    if (produced < HDEPTH) produced++;
  endtask

  // decode one compressed byte into its expected output bytes
  task automatic decode_byte(input logic [7:0] b, input logic last);
    int                n;
    int                i;
    int                len;
    logic [15:0]       word;
    logic [DIST_W-1:0] copy_dist;
    logic [DIST_W-1:0] idx;
    n = byte_q.size();
    if (run_left != 0) begin
      run_left = run_left - 1'b1;
      emit_byte(b, 1'b0);
    end else if (pair_pend) begin
      word      = {pair_hi, b};
      copy_dist = word[13:3];
      len       = int'(b[2:0]) + int'(LEN_BIAS);
      pair_pend = 1'b0;
      pair_hi   = '0;
      for (i = 0; i < len; i++) begin
        if (copy_dist == 0 || int'(copy_dist) > produced) begin
          emit_byte(8'h00, 1'b1);
        end else begin
          idx = wr_ptr - copy_dist;
          emit_byte(hist[idx], 1'b0);
        end
      end
    end else if (b >= SPACE_MIN) begin
      emit_byte(SPACE_CHAR, 1'b0);
      emit_byte(b ^ XOR_MASK, 1'b0);
    end else if (b >= PAIR_MIN) begin
      pair_pend = 1'b1;
      pair_hi   = b;
    end else if (b >= PASS_MIN || b == 8'h00) begin
      emit_byte(b, 1'b0);
    end else begin
      run_left = b[3:0];
    end
    // mark the final byte caused by this request
    if (byte_q.size() > n) byte_q[byte_q.size()-1].last = 1'b1;
    if (last) begin
      wr_ptr    = '0;
      produced  = 0;
      run_left  = '0;
      pair_pend = 1'b0;
      pair_hi   = '0;
    end
  endtask

  task automatic push_comp(input logic [7:0] b, input logic last, input logic hold);
    comp_t c;
    c.data = b;
    c.last = last;
    c.hold = hold;
    comp_q.push_back(c);
  endtask

  // build one record of tokens; long records copy ten bytes per pair
  task automatic add_record(input int tokens, input bit long_copy, input bit hold_first);
    comp_t      rec[$];
    comp_t      c;
    int         t;
    int         k;
    int         kind;
    int         made;
    int         cap;
    int         cut;
    logic [10:0] back_dist;
    logic [2:0]  len;
    made = 0;
    c.last = 1'b0;
    c.hold = 1'b0;
    for (t = 0; t < tokens; t++) begin
      kind = long_copy ? ((t < 3) ? 0 : 60) : $urandom_range(99);
      if (kind < 20) begin
        // pass-through byte
        c.data = ($urandom_range(10) == 0) ? 8'h00 : 8'($urandom_range(9, 127));
        rec.push_back(c);
        made += 1;
      end else if (kind < 35) begin
        // space plus character
        c.data = 8'($urandom_range(192, 255));
        rec.push_back(c);
        made += 2;
      end else if (kind < 55) begin
        // literal run
        k = $urandom_range(1, 8);
        c.data = 8'(k);
        rec.push_back(c);
        repeat (k) begin
          c.data = 8'($urandom_range(255));
          rec.push_back(c);
        end
        made += k;
      end else if (kind < 92) begin
        // back-reference pair
        len = long_copy ? 3'd7 : 3'($urandom_range(7));
        cap = (made > HDEPTH - 1) ? HDEPTH - 1 : made;
        if (made > 0 && $urandom_range(99) < 85) begin
          if ($urandom_range(19) == 0) back_dist = 11'(cap);
          else if ($urandom_range(1)) back_dist = 11'($urandom_range(1, (cap < 16) ? cap : 16));
          else back_dist = 11'($urandom_range(1, cap));
        end else begin
          back_dist = $urandom_range(1) ? 11'd0 : 11'($urandom_range(1, HDEPTH - 1));
        end
        c.data = {2'b10, back_dist[10:5]};
        rec.push_back(c);
        c.data = {back_dist[4:0], len};
        rec.push_back(c);
        made += int'(len) + 3;
      end else begin
        // noise byte, sometimes ending the record early
        c.data = 8'($urandom_range(255));
        c.last = ($urandom_range(9) == 0);
        rec.push_back(c);
        c.last = 1'b0;
      end
    end
    // some records are cut short, possibly inside a run or a pair
    if (!long_copy && $urandom_range(99) < 15) begin
      cut = $urandom_range(0, rec.size() - 1);
      while (rec.size() > cut + 1) void'(rec.pop_back());
    end
    rec[rec.size()-1].last = 1'b1;
    rec[0].hold = hold_first;
    foreach (rec[j]) comp_q.push_back(rec[j]);
  endtask

  // driver: presents pending compressed bytes, decodes each on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        decode_byte(in_tdata, in_tlast);
        void'(comp_q.pop_front());
        n_acc++;
      end
      if (comp_q.size() == 0 || (comp_q[0].hold && byte_q.size() != 0) ||
          $urandom_range(99) < send_idle) begin
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= comp_q[0].data;
        in_tlast  <= comp_q[0].last;
      end
    end
  end

  // monitor: compares each accepted output byte with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (byte_q.size() == 0) begin
          $error("unexpected output byte %02h", out_tdata);
          n_err++;
        end else begin
          want = byte_q.pop_front();
          if (out_tdata !== want.data) begin
            $error("out_byte: expected %02h, actual %02h", want.data, out_tdata);
            n_err++;
          end
          if (out_tlast !== want.last) begin
            $error("out_last: expected %0b, actual %0b", want.last, out_tlast);
            n_err++;
          end
          if (out_tuser !== want.bad) begin
            $error("bad_distance: expected %0b, actual %0b", want.bad, out_tuser);
            n_err++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // stimulus and end of run
  initial begin
    int r;
    foreach (hist[j]) hist[j] = 8'h00;
    // byte class extremes
    push_comp(8'h00, 1'b0, 1'b0);
    push_comp(8'h09, 1'b0, 1'b0);
    push_comp(8'h7F, 1'b0, 1'b0);
    push_comp(8'hC0, 1'b0, 1'b0);
    push_comp(8'hFF, 1'b0, 1'b0);
    // longest literal run carrying bytes of every class
    push_comp(8'h08, 1'b0, 1'b0);
    push_comp(8'h00, 1'b0, 1'b0);
    push_comp(8'hFF, 1'b0, 1'b0);
    push_comp(8'h80, 1'b0, 1'b0);
    push_comp(8'h01, 1'b0, 1'b0);
    push_comp(8'h08, 1'b0, 1'b0);
    push_comp(8'hC0, 1'b0, 1'b0);
    push_comp(8'h55, 1'b0, 1'b0);
    push_comp(8'hAA, 1'b0, 1'b0);
    // distance one, length ten: fully overlapping copy
    push_comp(8'h80, 1'b0, 1'b0);
    push_comp(8'h0F, 1'b0, 1'b0);
    // zero distance
    push_comp(8'h80, 1'b0, 1'b0);
    push_comp(8'h00, 1'b0, 1'b0);
    // largest distance, beyond what has been produced
    push_comp(8'hBF, 1'b0, 1'b0);
    push_comp(8'hFF, 1'b0, 1'b0);
    // record end, then a copy that is bad only for its first byte
    push_comp(8'h41, 1'b1, 1'b0);
    push_comp(8'h80, 1'b0, 1'b0);
    push_comp(8'h0B, 1'b0, 1'b0);
    // record ends on a pair high byte and on a run count
    push_comp(8'h85, 1'b1, 1'b0);
    push_comp(8'h05, 1'b1, 1'b0);
    // random records, one of them pass bytes then longest copies
    r = 0;
    while (comp_q.size() < 100) begin
      add_record($urandom_range(3, 30), 1'b0, (r == 0));
      r++;
    end
    add_record(40, 1'b1, 1'b1);
    while (comp_q.size() < 200) add_record($urandom_range(3, 30), 1'b0, 1'b0);
    n_total = comp_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (comp_q.size() != 0 || byte_q.size() != 0);
    // allow the block to finish and catch stray output
    repeat (20) @(negedge clk);
    if (n_err == 0 && byte_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
